>>> src/i2crts_pkg.sv
package i2crts_pkg;

  typedef enum logic [2:0] {
    PH_SB   = 3'd0,
    PH_ADDR = 3'd1,
    PH_TXE  = 3'd2,
    PH_RXNE = 3'd3,
    PH_BTF  = 3'd4,
    PH_IDLE = 3'd5
  } phase_t;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_EVENT = 1'b1;

  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  // one handler per flag, so an event item yields at most this many results
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  typedef struct packed {
    logic       dr_write;
    logic [7:0] dr_value;
    logic       start_request;
    logic       stop_request;
    logic [1:0] ack_control;
    logic       read_valid;
    logic [7:0] read_value;
    logic       done_res;
    logic       irq_disable;
    logic       last_of_run;
  } res_t;

endpackage

>>> src/i2c_register_transfer_sequencer_core.sv
// I2C master sequencer for register-addressed reads and writes. A start item
// (mode 0) loads the slave address, register address, byte count and direction
// and yields one START request; an event item (mode 1) carries the SB, ADDR,
// TXE, RXNE and BTF flags, which are checked in that order against the current
// phase, each firing handler giving one result (data-register write, ACK
// control, START/STOP request, received byte, done). An item yields zero to
// five results, the last marked by last_of_run. The transfer state is updated
// in the cycle the item is taken and its results are held in a five-entry
// buffer that drains one result per cycle into the output register while the
// output is not stalled, so a sustained rate is one item per cycle for items
// with at most one result; the next item is taken in the cycle its
// predecessor's last result moves into the output register.
module i2c_register_transfer_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic       is_read,
  input  logic [6:0] slave_address,
  input  logic [7:0] register_address,
  input  logic [7:0] byte_count,
  input  logic       flag_start_sent,
  input  logic       flag_address_sent,
  input  logic       flag_tx_empty,
  input  logic       flag_rx_full,
  input  logic       flag_tx_finished,
  input  logic [7:0] tx_byte,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       dr_write,
  output logic [7:0] dr_value,
  output logic       start_request,
  output logic       stop_request,
  output logic [1:0] ack_control,
  output logic       read_valid,
  output logic [7:0] read_value,
  output logic       done_res,
  output logic       irq_disable,
  output logic       last_of_run
);

  localparam int unsigned NRes = i2crts_pkg::MaxResults;
  localparam int unsigned CW   = i2crts_pkg::CountW;
  localparam int unsigned IdxW = $clog2(NRes);

  // transfer state
  i2crts_pkg::phase_t phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [6:0] target_address, target_address_next;
  logic [7:0] target_register, target_register_next;
  logic       read_transfer, read_transfer_next;
  logic       register_sent, register_sent_next;
  logic       direction_bit, direction_bit_next;
  logic       data_send_enabled, data_send_enabled_next;

  // result buffer and output register
  i2crts_pkg::res_t res_buf [NRes];
  i2crts_pkg::res_t res_new [NRes];
  logic [CW-1:0]    buf_count, buf_index, new_count;
  i2crts_pkg::res_t out_res;

  // handler chain
  i2crts_pkg::phase_t ph1, ph2, ph3, ph4;
  logic [7:0] bl3, bl4;
  logic       dse2;
  logic       fire_sb, fire_ad, fire_tx, fire_rx, fire_bt;

  logic buf_has, load, in_acc;

  assign buf_has  = buf_index != buf_count;
  assign load     = buf_has && (!out_valid || !out_stall);
  assign in_stall = buf_has && !(load && (buf_index == buf_count - CW'(1)));
  assign in_acc   = in_valid && !in_stall;

  // next state
  always_comb begin
    phase_next             = phase;
    bytes_left_next        = bytes_left;
    target_address_next    = target_address;
    target_register_next   = target_register;
    read_transfer_next     = read_transfer;
    register_sent_next     = register_sent;
    direction_bit_next     = direction_bit;
    data_send_enabled_next = data_send_enabled;
    ph1 = phase; ph2 = phase; ph3 = phase; ph4 = phase;
    bl3 = bytes_left; bl4 = bytes_left;
    dse2 = data_send_enabled;
    fire_sb = 1'b0; fire_ad = 1'b0; fire_tx = 1'b0; fire_rx = 1'b0; fire_bt = 1'b0;

    if (mode == i2crts_pkg::MODE_START) begin
      read_transfer_next     = is_read;
      target_address_next    = slave_address;
      target_register_next   = register_address;
      bytes_left_next        = (byte_count == 8'd0) ? 8'd1 : byte_count;
      register_sent_next     = 1'b0;
      direction_bit_next     = 1'b0;
      data_send_enabled_next = 1'b0;
      phase_next             = i2crts_pkg::PH_SB;
    end else begin
      fire_sb = flag_start_sent && (phase == i2crts_pkg::PH_SB);
      ph1 = fire_sb ? i2crts_pkg::PH_ADDR : phase;

      fire_ad = flag_address_sent && (ph1 == i2crts_pkg::PH_ADDR);
      ph2 = ph1;
      if (fire_ad) begin
        if (!read_transfer) begin
          ph2  = i2crts_pkg::PH_TXE;
          dse2 = 1'b1;
        end else if (register_sent) begin
          ph2 = i2crts_pkg::PH_RXNE;
        end else begin
          ph2 = i2crts_pkg::PH_TXE;
          register_sent_next = 1'b1;
        end
      end

      ph3 = ph2;
      if (flag_tx_empty && (ph2 == i2crts_pkg::PH_TXE)) begin
        if (!read_transfer) begin
          if (dse2) begin
            fire_tx = 1'b1;
            bl3 = bytes_left - 8'd1;
            if (bl3 == 8'd0) ph3 = i2crts_pkg::PH_BTF;
          end
        end else begin
          fire_tx = 1'b1;
          direction_bit_next = 1'b1;
          ph3 = i2crts_pkg::PH_SB;
        end
      end

      fire_rx = flag_rx_full && (ph3 == i2crts_pkg::PH_RXNE);
      bl4 = bl3;
      ph4 = ph3;
      if (fire_rx) begin
        bl4 = bl3 - 8'd1;
        if (bl4 == 8'd0) ph4 = i2crts_pkg::PH_IDLE;
      end

      fire_bt = flag_tx_finished && (ph4 == i2crts_pkg::PH_BTF);

      phase_next             = fire_bt ? i2crts_pkg::PH_IDLE : ph4;
      bytes_left_next        = bl4;
      data_send_enabled_next = dse2;
    end
  end

  // results of the item, packed in handler order
  always_comb begin
    i2crts_pkg::res_t cand [NRes];
    logic [NRes-1:0]  fire;
    logic [CW-1:0]    idx;

    for (int k = 0; k < NRes; k++) begin
      cand[k]    = '0;
      res_new[k] = '0;
    end
    fire = '0;
    idx  = '0;

    if (mode == i2crts_pkg::MODE_START) begin
      res_new[0].start_request = 1'b1;
      res_new[0].last_of_run   = 1'b1;
      new_count = CW'(1);
    end else begin
      fire = {fire_bt, fire_rx, fire_tx, fire_ad, fire_sb};

      cand[0].dr_write = 1'b1;
      cand[0].dr_value = {target_address, direction_bit};

      if (!read_transfer || !register_sent) begin
        cand[1].dr_write = 1'b1;
        cand[1].dr_value = target_register;
      end else if (bytes_left == 8'd1) begin
        cand[1].ack_control  = i2crts_pkg::ACK_DISABLE;
        cand[1].stop_request = 1'b1;
      end else begin
        cand[1].ack_control = i2crts_pkg::ACK_ENABLE;
      end

      if (!read_transfer) begin
        cand[2].dr_write = 1'b1;
        cand[2].dr_value = tx_byte;
      end else begin
        cand[2].start_request = 1'b1;
      end

      cand[3].read_valid = 1'b1;
      cand[3].read_value = rx_byte;
      if (bl4 == 8'd1) begin
        cand[3].ack_control  = i2crts_pkg::ACK_DISABLE;
        cand[3].stop_request = 1'b1;
      end
      cand[3].done_res = (bl4 == 8'd0);

      cand[4].stop_request = 1'b1;
      cand[4].irq_disable  = 1'b1;
      cand[4].done_res     = 1'b1;

      for (int k = 0; k < NRes; k++) begin
        if (fire[k]) begin
          res_new[idx[IdxW-1:0]] = cand[k];
          idx = idx + CW'(1);
        end
      end
      if (idx != '0) res_new[idx[IdxW-1:0] - IdxW'(1)].last_of_run = 1'b1;
      new_count = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      buf_count         <= '0;
      buf_index         <= '0;
      phase             <= i2crts_pkg::PH_SB;
      bytes_left        <= '0;
      target_address    <= '0;
      target_register   <= '0;
      read_transfer     <= 1'b0;
      register_sent     <= 1'b0;
      direction_bit     <= 1'b0;
      data_send_enabled <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // a new item restarts the read pointer, even while the last result leaves
      if (in_acc) begin
        buf_index <= '0;
      end else if (load) begin
        buf_index <= buf_index + CW'(1);
      end
      if (in_acc) begin
        buf_count         <= new_count;
        phase             <= phase_next;
        bytes_left        <= bytes_left_next;
        target_address    <= target_address_next;
        target_register   <= target_register_next;
        read_transfer     <= read_transfer_next;
        register_sent     <= register_sent_next;
        direction_bit     <= direction_bit_next;
        data_send_enabled <= data_send_enabled_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) out_res <= res_buf[buf_index[IdxW-1:0]];
    if (in_acc) begin
      for (int k = 0; k < NRes; k++) res_buf[k] <= res_new[k];
    end
  end

  assign dr_write      = out_res.dr_write;
  assign dr_value      = out_res.dr_value;
  assign start_request = out_res.start_request;
  assign stop_request  = out_res.stop_request;
  assign ack_control   = out_res.ack_control;
  assign read_valid    = out_res.read_valid;
  assign read_value    = out_res.read_value;
  assign done_res      = out_res.done_res;
  assign irq_disable   = out_res.irq_disable;
  assign last_of_run   = out_res.last_of_run;

endmodule
